FILE: rtl/btt_pkg.sv
// Shared types and constants for the beta trust table.
package btt_pkg;

   localparam int FUNC_W  = 2;
   localparam int ID_W    = 32;
   localparam int TRUST_W = 16;
   localparam int COUNT_W = 32;

   localparam logic [FUNC_W-1:0] FUNC_ACK  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_NACK = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ = 2'd2;

   typedef struct packed {
      logic start;
      logic scan;
      logic load;
      logic incr;
      logic div_init;
      logic div_step;
      logic out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic match;
      logic miss;
      logic full;
      logic div_done;
      logic out_free;
   } dp_stat_type;

endpackage

FILE: rtl/btt_ctrl.sv
// Controller state machine for the beta trust table.
module btt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  btt_pkg::dp_stat_type  stat,
   output btt_pkg::ctrl_cmd_type cmd
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SCAN   = 6'b000010,
      ST_UPDATE = 6'b000100,
      ST_WRITE  = 6'b001000,
      ST_DIV    = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.match || stat.miss) begin
               cmd.load = 1'b1;
               // A new node that finds no free slot skips straight to the result.
               if (!stat.match && stat.full) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_UPDATE;
               end
            end
         end
         ST_UPDATE: begin
            cmd.incr = 1'b1;
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            cmd.div_init = 1'b1;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            if (stat.div_done) begin
               state_in = ST_DONE;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_DONE: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/btt_dp.sv
// Datapath of the beta trust table: slot memory, scan, counters, divider, result register.
module btt_dp #(
   parameter int ENTRIES         = 16,
   parameter int COUNT_WIDTH     = 32,
   parameter int TRUST_FRAC_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  btt_pkg::ctrl_cmd_type        cmd,
   output btt_pkg::dp_stat_type         stat,
   input  logic [btt_pkg::FUNC_W-1:0]   req_func,
   input  logic [btt_pkg::ID_W-1:0]     req_node_id,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [btt_pkg::TRUST_W-1:0]  rsp_trust,
   output logic [btt_pkg::COUNT_W-1:0]  rsp_ack_count,
   output logic [btt_pkg::COUNT_W-1:0]  rsp_nack_count,
   output logic                         rsp_table_full
);

   localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int FILL_W = $clog2(ENTRIES + 1);
   localparam int DEN_W  = COUNT_WIDTH + 2;
   localparam int STEP_W = $clog2(TRUST_FRAC_BITS + 1);
   localparam int QW     = (TRUST_FRAC_BITS > btt_pkg::TRUST_W) ? TRUST_FRAC_BITS
                                                                : btt_pkg::TRUST_W;
   localparam logic [QW-1:0] HALF = QW'(1) << (TRUST_FRAC_BITS - 1);

   // Slot memory; valid slots are always 0 .. fill-1 since slots are never freed.
   logic [btt_pkg::ID_W-1:0] node_mem [ENTRIES];
   logic [COUNT_WIDTH-1:0]   ack_mem  [ENTRIES];
   logic [COUNT_WIDTH-1:0]   nack_mem [ENTRIES];

   logic [btt_pkg::ID_W-1:0] node_rd_ff;
   logic [COUNT_WIDTH-1:0]   ack_rd_ff;
   logic [COUNT_WIDTH-1:0]   nack_rd_ff;

   logic [btt_pkg::FUNC_W-1:0] func_ff;
   logic [btt_pkg::ID_W-1:0]   id_ff;

   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [FILL_W-1:0] rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]  cmp_idx_ff, cmp_idx_in;
   logic              cmp_vld_ff, cmp_vld_in;
   logic              rd_en;

   logic [COUNT_WIDTH-1:0] acks_ff, acks_in;
   logic [COUNT_WIDTH-1:0] nacks_ff, nacks_in;
   logic [IDX_W-1:0]       slot_ff, slot_in;
   logic                   full_ff, full_in;

   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [QW-1:0]     q_ff, q_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DEN_W:0]    rem_dbl;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [btt_pkg::TRUST_W-1:0]  trust_ff;
   logic [btt_pkg::COUNT_W-1:0]  ack_out_ff;
   logic [btt_pkg::COUNT_W-1:0]  nack_out_ff;
   logic                         full_out_ff;

   assign stat.match    = cmp_vld_ff && (node_rd_ff == id_ff);
   assign stat.miss     = !cmp_vld_ff && (rd_idx_ff == fill_ff);
   assign stat.full     = (fill_ff == FILL_W'(ENTRIES));
   assign stat.div_done = (step_ff == STEP_W'(TRUST_FRAC_BITS));
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   assign rd_en   = cmd.scan && (rd_idx_ff < fill_ff);
   assign rem_dbl = {rem_ff, 1'b0};

   always_comb begin
      rd_idx_in  = rd_idx_ff;
      cmp_idx_in = cmp_idx_ff;
      cmp_vld_in = 1'b0;
      fill_in    = fill_ff;
      acks_in    = acks_ff;
      nacks_in   = nacks_ff;
      slot_in    = slot_ff;
      full_in    = full_ff;
      rem_in     = rem_ff;
      den_in     = den_ff;
      q_in       = q_ff;
      step_in    = step_ff;

      if (cmd.start) begin
         rd_idx_in = '0;
      end
      if (rd_en) begin
         cmp_idx_in = rd_idx_ff[IDX_W-1:0];
         cmp_vld_in = 1'b1;
         rd_idx_in  = rd_idx_ff + FILL_W'(1);
      end

      if (cmd.load) begin
         if (stat.match) begin
            acks_in  = ack_rd_ff;
            nacks_in = nack_rd_ff;
            slot_in  = cmp_idx_ff;
            full_in  = 1'b0;
         end else begin
            acks_in  = '0;
            nacks_in = '0;
            slot_in  = fill_ff[IDX_W-1:0];
            full_in  = stat.full;
            if (!stat.full) begin
               fill_in = fill_ff + FILL_W'(1);
            end
         end
      end

      if (cmd.incr) begin
         case (func_ff)
            btt_pkg::FUNC_ACK: begin
               if (!(&acks_ff)) begin
                  acks_in = acks_ff + COUNT_WIDTH'(1);
               end
            end
            btt_pkg::FUNC_NACK: begin
               if (!(&nacks_ff)) begin
                  nacks_in = nacks_ff + COUNT_WIDTH'(1);
               end
            end
            default: begin
            end
         endcase
      end

      if (cmd.div_init) begin
         rem_in  = DEN_W'(acks_ff) + DEN_W'(1);
         den_in  = DEN_W'(acks_ff) + DEN_W'(nacks_ff) + DEN_W'(2);
         q_in    = '0;
         step_in = '0;
      end

      // One restoring step per cycle; the remainder always stays below the divisor.
      if (cmd.div_step) begin
         if (rem_dbl >= {1'b0, den_ff}) begin
            rem_in = DEN_W'(rem_dbl - {1'b0, den_ff});
            q_in   = {q_ff[QW-2:0], 1'b1};
         end else begin
            rem_in = rem_dbl[DEN_W-1:0];
            q_in   = {q_ff[QW-2:0], 1'b0};
         end
         step_in = step_ff + STEP_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rd_idx_ff    <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         rd_idx_ff    <= rd_idx_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         func_ff <= req_func;
         id_ff   <= req_node_id;
      end
      cmp_idx_ff <= cmp_idx_in;
      acks_ff    <= acks_in;
      nacks_ff   <= nacks_in;
      slot_ff    <= slot_in;
      full_ff    <= full_in;
      rem_ff     <= rem_in;
      den_ff     <= den_in;
      q_ff       <= q_in;
      step_ff    <= step_in;
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         node_rd_ff <= node_mem[rd_idx_ff[IDX_W-1:0]];
         ack_rd_ff  <= ack_mem[rd_idx_ff[IDX_W-1:0]];
         nack_rd_ff <= nack_mem[rd_idx_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         node_mem[slot_ff] <= id_ff;
         ack_mem[slot_ff]  <= acks_ff;
         nack_mem[slot_ff] <= nacks_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         if (full_ff) begin
            trust_ff    <= HALF[btt_pkg::TRUST_W-1:0];
            ack_out_ff  <= '0;
            nack_out_ff <= '0;
            full_out_ff <= 1'b1;
         end else begin
            trust_ff    <= q_ff[btt_pkg::TRUST_W-1:0];
            ack_out_ff  <= btt_pkg::COUNT_W'(acks_ff);
            nack_out_ff <= btt_pkg::COUNT_W'(nacks_ff);
            full_out_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_trust      = trust_ff;
   assign rsp_ack_count  = ack_out_ff;
   assign rsp_nack_count = nack_out_ff;
   assign rsp_table_full = full_out_ff;

endmodule

FILE: rtl/beta_trust_table.sv
// Top level of the beta trust table: per-node ack/nack counts and beta-mean trust.
//
// Usage: each request on the req_ channel names a node and an operation (count an
// ack, count a nack, or read only). Exactly one response follows on the rsp_ channel
// with the node's trust as an unsigned Q0.16 fraction, its saturating counts, and a
// table_full flag for a new node that found no free slot (then trust reads 0.5).
// Unknown nodes take the lowest free slot with both counts at zero.
// Operation: the slot memory is scanned one slot per cycle through its single read
// port, then a restoring divider produces one trust bit per cycle. The scan stops
// at the node's slot; for a new node it runs over all fill slots in use. A new node
// that meets a full table skips the divider. One request is worked on at a time;
// req_ready is high only while the block is idle.
// Reset empties the table at once through the fill count; no clearing pass is needed.
// The response is held in an output register. The next request may be accepted
// while it waits, but that request's response waits until rsp_ready takes the old one.
module beta_trust_table #(
   parameter int ENTRIES         = 16,
   parameter int COUNT_WIDTH     = 32,
   parameter int TRUST_FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [btt_pkg::FUNC_W-1:0]  req_func,
   input  logic [btt_pkg::ID_W-1:0]    req_node_id,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [btt_pkg::TRUST_W-1:0] rsp_trust,
   output logic [btt_pkg::COUNT_W-1:0] rsp_ack_count,
   output logic [btt_pkg::COUNT_W-1:0] rsp_nack_count,
   output logic                        rsp_table_full
);

   btt_pkg::ctrl_cmd_type cmd;
   btt_pkg::dp_stat_type  stat;

   btt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   btt_dp #(
      .ENTRIES         (ENTRIES),
      .COUNT_WIDTH     (COUNT_WIDTH),
      .TRUST_FRAC_BITS (TRUST_FRAC_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_func       (req_func),
      .req_node_id    (req_node_id),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_trust      (rsp_trust),
      .rsp_ack_count  (rsp_ack_count),
      .rsp_nack_count (rsp_nack_count),
      .rsp_table_full (rsp_table_full)
   );

endmodule
